[hdl/single_source_shortest_path_assert.svh]
// Assertion macros for the shortest path block.
// Used by the top level; depends on nothing.
`ifndef SINGLE_SOURCE_SHORTEST_PATH_ASSERT_SVH
`define SINGLE_SOURCE_SHORTEST_PATH_ASSERT_SVH

// same-cycle implication
`define SSSP_ASSERT_NOW(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |-> (cons)) \
        else $error("sssp assertion failed");

// next-cycle implication
`define SSSP_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |=> (cons)) \
        else $error("sssp assertion failed");

`endif

[hdl/sssp_pkg.sv]
// Shared types, constants and helpers for the shortest path block.
// No dependencies.
package sssp_pkg;

    localparam int MAX_VERTICES = 64;
    localparam int MAX_EDGES    = 256;
    localparam int WEIGHT_BITS  = 16;
    localparam int DIST_BITS    = 22;

    localparam int VERT_BITS  = $clog2(MAX_VERTICES);
    localparam int COUNT_BITS = VERT_BITS + 1;
    localparam int EDGE_BITS  = $clog2(MAX_EDGES);
    localparam int TOTAL_BITS = EDGE_BITS + 1;

    localparam int CFG_INDEX_BITS = 2;
    localparam int CFG_DATA_BITS  = 7;

    localparam logic [CFG_INDEX_BITS-1:0] CFG_VERTEX_COUNT  = 2'd0;
    localparam logic [CFG_INDEX_BITS-1:0] CFG_SOURCE_VERTEX = 2'd1;

    localparam logic [DIST_BITS-1:0] DIST_MAX = '1;

    typedef logic [VERT_BITS-1:0]   t_vidx;
    typedef logic [COUNT_BITS-1:0]  t_count;
    typedef logic [EDGE_BITS-1:0]   t_eidx;
    typedef logic [TOTAL_BITS-1:0]  t_total;
    typedef logic [WEIGHT_BITS-1:0] t_weight;
    typedef logic [DIST_BITS-1:0]   t_dist;

    typedef struct packed {
        t_vidx   tail;
        t_vidx   head;
        t_weight weight;
    } t_arc;

    typedef struct packed {
        logic  en;
        t_eidx addr;
    } t_arc_rd;

    typedef enum logic [3:0] {
        S_IDLE,
        S_INIT,
        S_SCAN,
        S_SCAN_END,
        S_PICK,
        S_RELAX,
        S_DRAIN,
        S_OUT_RD,
        S_OUT_LD
    } t_state;

    // zero acts as one, anything above the maximum as the maximum
    function automatic t_count active_count(input logic [CFG_DATA_BITS-1:0] raw);
        t_count res;
        if (raw == '0) begin
            res = t_count'(1);
        end else if (raw > CFG_DATA_BITS'(MAX_VERTICES)) begin
            res = t_count'(MAX_VERTICES);
        end else begin
            res = t_count'(raw);
        end
        return res;
    endfunction

endpackage

[hdl/sssp_in_if.sv]
// Edge input channel: valid/ready handshake carrying one edge word.
// Depends on sssp_pkg.
interface sssp_in_if import sssp_pkg::*;;
    logic    valid;
    logic    ready;
    logic    has_edge;
    t_vidx   from_vertex;
    t_vidx   to_vertex;
    t_weight edge_weight;
    logic    last_edge;

    modport source (output valid, has_edge, from_vertex, to_vertex, edge_weight, last_edge,
                    input ready);
    modport sink (input valid, has_edge, from_vertex, to_vertex, edge_weight, last_edge,
                  output ready);
endinterface

[hdl/sssp_out_if.sv]
// Result channel: valid/ready handshake carrying one distance word.
// Depends on sssp_pkg.
interface sssp_out_if import sssp_pkg::*;;
    logic  valid;
    logic  ready;
    t_vidx vertex_index;
    t_dist distance;
    logic  reachable;
    logic  edge_overflow;
    logic  last_vertex;

    modport source (output valid, vertex_index, distance, reachable, edge_overflow, last_vertex,
                    input ready);
    modport sink (input valid, vertex_index, distance, reachable, edge_overflow, last_vertex,
                  output ready);
endinterface

[hdl/sssp_edge_store.sv]
// Edge memory with fill count and overflow flag.
// Depends on sssp_pkg.
module sssp_edge_store import sssp_pkg::*; (
    input  logic    i_clk,
    input  logic    i_rst_n,
    input  logic    i_load,
    input  t_arc    i_arc,
    input  logic    i_clear,
    input  t_arc_rd i_rd,
    output t_arc    o_rd_arc,
    output t_total  o_total,
    output logic    o_overflow
);

    t_arc   r_mem [MAX_EDGES];
    t_arc   r_rd_arc;
    t_total r_total;
    logic   r_overflow;
    logic   full;

    assign full = (r_total == t_total'(MAX_EDGES));

    always_ff @(posedge i_clk) begin
        if (i_load && !full) begin
            r_mem[r_total[EDGE_BITS-1:0]] <= i_arc;
        end
        if (i_rd.en) begin
            r_rd_arc <= r_mem[i_rd.addr];
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_total    <= '0;
            r_overflow <= 1'b0;
        end else if (i_clear) begin
            r_total    <= '0;
            r_overflow <= 1'b0;
        end else if (i_load) begin
            if (full) begin
                r_overflow <= 1'b1;
            end else begin
                r_total <= r_total + 1'b1;
            end
        end
    end

    assign o_rd_arc   = r_rd_arc;
    assign o_total    = r_total;
    assign o_overflow = r_overflow;

endmodule

[hdl/sssp_solver.sv]
// Sequencer: min scan, edge relaxation over the distance memory, result output.
// Depends on sssp_pkg, sssp_out_if and the edge store read port.
module sssp_solver import sssp_pkg::*; (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_start,
    input  t_count      i_cnt,
    input  t_vidx       i_src,
    input  t_total      i_total,
    input  logic        i_overflow,
    input  t_arc        i_arc,
    output t_arc_rd     o_arc_rd,
    output logic        o_clear,
    output logic        o_idle,
    sssp_out_if.source  o_dist
);

    t_dist r_dist_mem [MAX_VERTICES];
    t_dist r_dist_rd;

    t_state r_state, n_state;
    logic [MAX_VERTICES-1:0] r_reached, n_reached;
    logic [MAX_VERTICES-1:0] r_finished, n_finished;
    t_vidx   r_idx, n_idx;
    t_eidx   r_eidx, n_eidx;
    logic    r_cmp_vld, n_cmp_vld;
    t_vidx   r_cmp_idx, n_cmp_idx;
    logic    r_found, n_found;
    t_dist   r_best, n_best;
    t_vidx   r_u, n_u;
    logic    r_e1_vld, n_e1_vld;
    logic    r_e2_vld, n_e2_vld;
    t_vidx   r_e2_head, n_e2_head;
    t_weight r_e2_w, n_e2_w;
    logic    r_wb_vld, n_wb_vld;
    t_vidx   r_wb_addr, n_wb_addr;
    t_dist   r_wb_data, n_wb_data;
    logic    r_out_valid, n_out_valid;
    t_vidx   r_out_index, n_out_index;
    t_dist   r_out_dist, n_out_dist;
    logic    r_out_reach, n_out_reach;
    logic    r_out_ovf, n_out_ovf;
    logic    r_out_last, n_out_last;

    logic    dist_we, dist_re;
    t_vidx   dist_waddr, dist_raddr;
    t_dist   dist_wdata;
    t_vidx   last_idx;
    t_dist   d_old, nd;
    logic [DIST_BITS:0] sum;

    assign last_idx = t_vidx'(i_cnt - 1'b1);

    always_ff @(posedge i_clk) begin
        if (dist_we) begin
            r_dist_mem[dist_waddr] <= dist_wdata;
        end
        if (dist_re) begin
            r_dist_rd <= r_dist_mem[dist_raddr];
        end
    end

    always_comb begin
        n_state     = r_state;
        n_reached   = r_reached;
        n_finished  = r_finished;
        n_idx       = r_idx;
        n_eidx      = r_eidx;
        n_cmp_vld   = 1'b0;
        n_cmp_idx   = r_cmp_idx;
        n_found     = r_found;
        n_best      = r_best;
        n_u         = r_u;
        n_e1_vld    = 1'b0;
        n_e2_vld    = 1'b0;
        n_e2_head   = r_e2_head;
        n_e2_w      = r_e2_w;
        n_wb_vld    = 1'b0;
        n_wb_addr   = r_wb_addr;
        n_wb_data   = r_wb_data;
        n_out_valid = r_out_valid && !o_dist.ready;
        n_out_index = r_out_index;
        n_out_dist  = r_out_dist;
        n_out_reach = r_out_reach;
        n_out_ovf   = r_out_ovf;
        n_out_last  = r_out_last;
        dist_we     = 1'b0;
        dist_waddr  = r_wb_addr;
        dist_wdata  = r_wb_data;
        dist_re     = 1'b0;
        dist_raddr  = r_idx;
        o_arc_rd    = '{en: 1'b0, addr: r_eidx};
        o_clear     = 1'b0;

        // min scan compare, one vertex per cycle
        if (r_cmp_vld && r_reached[r_cmp_idx] && !r_finished[r_cmp_idx] &&
            (!r_found || r_dist_rd < r_best)) begin
            n_found = 1'b1;
            n_best  = r_dist_rd;
            n_u     = r_cmp_idx;
        end

        // relax stage 1: edge word back, fetch head distance
        if (r_e1_vld && i_arc.tail == r_u && {1'b0, i_arc.head} < i_cnt) begin
            dist_re    = 1'b1;
            dist_raddr = i_arc.head;
            n_e2_vld   = 1'b1;
            n_e2_head  = i_arc.head;
            n_e2_w     = i_arc.weight;
        end

        // relax stage 2: update; forward the write of the previous cycle
        d_old = (r_wb_vld && r_wb_addr == r_e2_head) ? r_wb_data : r_dist_rd;
        sum   = {1'b0, r_best} + (DIST_BITS+1)'(r_e2_w);
        nd    = sum[DIST_BITS] ? DIST_MAX : sum[DIST_BITS-1:0];
        if (r_e2_vld && (!r_reached[r_e2_head] || nd < d_old)) begin
            dist_we              = 1'b1;
            dist_waddr           = r_e2_head;
            dist_wdata           = nd;
            n_reached[r_e2_head] = 1'b1;
            n_wb_vld             = 1'b1;
            n_wb_addr            = r_e2_head;
            n_wb_data            = nd;
        end

        case (r_state)
            S_IDLE: begin
                if (i_start) begin
                    n_state = S_INIT;
                end
            end
            S_INIT: begin
                n_reached  = '0;
                n_finished = '0;
                n_found    = 1'b0;
                n_idx      = '0;
                if ({1'b0, i_src} < i_cnt) begin
                    n_reached[i_src] = 1'b1;
                    dist_we          = 1'b1;
                    dist_waddr       = i_src;
                    dist_wdata       = '0;
                    n_state          = S_SCAN;
                end else begin
                    n_state = S_OUT_RD;
                end
            end
            S_SCAN: begin
                dist_re    = 1'b1;
                dist_raddr = r_idx;
                n_cmp_vld  = 1'b1;
                n_cmp_idx  = r_idx;
                if (r_idx == last_idx) begin
                    n_state = S_SCAN_END;
                end else begin
                    n_idx = r_idx + 1'b1;
                end
            end
            S_SCAN_END: begin
                n_state = S_PICK;
            end
            S_PICK: begin
                n_idx = '0;
                if (!r_found) begin
                    n_state = S_OUT_RD;
                end else begin
                    n_finished[r_u] = 1'b1;
                    n_eidx          = '0;
                    if (i_total == '0) begin
                        n_found = 1'b0;
                        n_state = S_SCAN;
                    end else begin
                        n_state = S_RELAX;
                    end
                end
            end
            S_RELAX: begin
                o_arc_rd = '{en: 1'b1, addr: r_eidx};
                n_e1_vld = 1'b1;
                if ({1'b0, r_eidx} == t_total'(i_total - 1'b1)) begin
                    n_state = S_DRAIN;
                end else begin
                    n_eidx = r_eidx + 1'b1;
                end
            end
            S_DRAIN: begin
                if (!r_e1_vld && !r_e2_vld) begin
                    n_idx   = '0;
                    n_found = 1'b0;
                    n_state = S_SCAN;
                end
            end
            S_OUT_RD: begin
                dist_re    = 1'b1;
                dist_raddr = r_idx;
                n_state    = S_OUT_LD;
            end
            S_OUT_LD: begin
                if (!r_out_valid || o_dist.ready) begin
                    n_out_valid = 1'b1;
                    n_out_index = r_idx;
                    n_out_reach = r_reached[r_idx];
                    n_out_dist  = r_reached[r_idx] ? r_dist_rd : '0;
                    n_out_ovf   = i_overflow;
                    n_out_last  = (r_idx == last_idx);
                    if (r_idx == last_idx) begin
                        o_clear = 1'b1;
                        n_state = S_IDLE;
                    end else begin
                        n_idx   = r_idx + 1'b1;
                        n_state = S_OUT_RD;
                    end
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_reached   <= '0;
            r_finished  <= '0;
            r_idx       <= '0;
            r_eidx      <= '0;
            r_cmp_vld   <= 1'b0;
            r_found     <= 1'b0;
            r_e1_vld    <= 1'b0;
            r_e2_vld    <= 1'b0;
            r_wb_vld    <= 1'b0;
            r_out_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_reached   <= n_reached;
            r_finished  <= n_finished;
            r_idx       <= n_idx;
            r_eidx      <= n_eidx;
            r_cmp_vld   <= n_cmp_vld;
            r_found     <= n_found;
            r_e1_vld    <= n_e1_vld;
            r_e2_vld    <= n_e2_vld;
            r_wb_vld    <= n_wb_vld;
            r_out_valid <= n_out_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        r_cmp_idx   <= n_cmp_idx;
        r_best      <= n_best;
        r_u         <= n_u;
        r_e2_head   <= n_e2_head;
        r_e2_w      <= n_e2_w;
        r_wb_addr   <= n_wb_addr;
        r_wb_data   <= n_wb_data;
        r_out_index <= n_out_index;
        r_out_dist  <= n_out_dist;
        r_out_reach <= n_out_reach;
        r_out_ovf   <= n_out_ovf;
        r_out_last  <= n_out_last;
    end

    assign o_idle              = (r_state == S_IDLE);
    assign o_dist.valid        = r_out_valid;
    assign o_dist.vertex_index = r_out_index;
    assign o_dist.distance     = r_out_dist;
    assign o_dist.reachable    = r_out_reach;
    assign o_dist.edge_overflow = r_out_ovf;
    assign o_dist.last_vertex  = r_out_last;

endmodule

[hdl/single_source_shortest_path.sv]
// Edges load one word per cycle while idle. After the last word comes a setup state, then one
// round per reachable vertex plus a final round (no rounds when the source is out of range).
// A round is a min scan over the distance memory, then, when edges are stored, an edge memory
// sweep; then each result word is read from the distance memory and loaded for output, with
// output stalls. One graph at a time. Synchronous reset clears the sequencer, marks, edge count
// and overflow flag and resets vertex count to the maximum, source to 0; memories keep data.
module single_source_shortest_path import sssp_pkg::*; (
    input  logic                      i_clk,
    input  logic                      i_rst_n,
    input  logic                      i_cfg_wr_en,
    input  logic [CFG_INDEX_BITS-1:0] i_cfg_index,
    input  logic [CFG_DATA_BITS-1:0]  i_cfg_data,
    sssp_in_if.sink                   i_edge,
    sssp_out_if.source                o_dist
);

`include "single_source_shortest_path_assert.svh"

    logic [CFG_DATA_BITS-1:0] r_vertex_count;
    t_vidx   r_source_vertex;
    t_count  cnt;
    logic    accept, load, start, clear, idle, overflow;
    t_arc    wr_arc, rd_arc;
    t_arc_rd arc_rd;
    t_total  total;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vertex_count  <= CFG_DATA_BITS'(MAX_VERTICES);
            r_source_vertex <= '0;
        end else if (i_cfg_wr_en) begin
            case (i_cfg_index)
                CFG_VERTEX_COUNT:  r_vertex_count  <= i_cfg_data;
                CFG_SOURCE_VERTEX: r_source_vertex <= i_cfg_data[VERT_BITS-1:0];
                default: ;
            endcase
        end
    end

    assign cnt          = active_count(r_vertex_count);
    assign i_edge.ready = idle;
    assign accept       = i_edge.valid && i_edge.ready;
    assign load         = accept && i_edge.has_edge &&
                          ({1'b0, i_edge.from_vertex} < cnt) &&
                          ({1'b0, i_edge.to_vertex} < cnt);
    assign start        = accept && i_edge.last_edge;
    assign wr_arc       = '{tail: i_edge.from_vertex, head: i_edge.to_vertex,
                            weight: i_edge.edge_weight};

    sssp_edge_store u_edge_store (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_load     (load),
        .i_arc      (wr_arc),
        .i_clear    (clear),
        .i_rd       (arc_rd),
        .o_rd_arc   (rd_arc),
        .o_total    (total),
        .o_overflow (overflow)
    );

    sssp_solver u_solver (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_start    (start),
        .i_cnt      (cnt),
        .i_src      (r_source_vertex),
        .i_total    (total),
        .i_overflow (overflow),
        .i_arc      (rd_arc),
        .o_arc_rd   (arc_rd),
        .o_clear    (clear),
        .o_idle     (idle),
        .o_dist     (o_dist)
    );

    `SSSP_ASSERT_NEXT(a_busy_after_last, i_clk, i_rst_n, start, !i_edge.ready)
    `SSSP_ASSERT_NOW(a_no_load_midgraph, i_clk, i_rst_n,
        o_dist.valid && o_dist.ready && !o_dist.last_vertex, !i_edge.ready)
    `SSSP_ASSERT_NEXT(a_store_count, i_clk, i_rst_n,
        load && (total != t_total'(MAX_EDGES)), total == $past(total) + 1'b1)

endmodule

[bench/testbench.sv]
// Self-checking bench for single_source_shortest_path: edge words in, distance words out.
// Predicts the distance of every vertex per graph and checks each result word in order.
// Depends on sssp_pkg, sssp_in_if, sssp_out_if and the RTL top level.
module testbench;
    timeunit 1ns;
    timeprecision 1ps;
    import sssp_pkg::*;

    typedef struct {
        logic    has_edge;
        t_vidx   from_vertex;
        t_vidx   to_vertex;
        t_weight edge_weight;
        logic    last_edge;
    } edge_word_t;

    typedef struct {
        t_vidx vertex_index;
        t_dist distance;
        logic  reachable;
        logic  edge_overflow;
        logic  last_vertex;
    } dist_word_t;

    logic                      i_clk = 1'b0;
    logic                      i_rst_n = 1'b0;
    logic                      cfg_wr_en = 1'b0;
    logic [CFG_INDEX_BITS-1:0] cfg_index = '0;
    logic [CFG_DATA_BITS-1:0]  cfg_data = '0;

    sssp_in_if  edge_if ();
    sssp_out_if dist_if ();

    single_source_shortest_path u_dut (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cfg_wr_en (cfg_wr_en),
        .i_cfg_index (cfg_index),
        .i_cfg_data  (cfg_data),
        .i_edge      (edge_if),
        .o_dist      (dist_if)
    );

    always begin
        #1 i_clk = 1'b1;
        #1 i_clk = 1'b0;
    end

    // shadow of the block
    logic [CFG_DATA_BITS-1:0] vcount_reg = 7'd64;
    t_vidx                    source_reg = '0;
    t_arc                     arc_store [MAX_EDGES];
    t_total                   arc_total = '0;
    logic                     arcs_dropped = 1'b0;

    edge_word_t  edges_pending [$];
    dist_word_t  dist_expected [$];
    int unsigned words_queued = 0;
    int          mismatches = 0;

    function automatic int unsigned live_count();
        if (vcount_reg == '0) begin
            return 1;
        end
        if (vcount_reg > MAX_VERTICES) begin
            return MAX_VERTICES;
        end
        return vcount_reg;
    endfunction

    function automatic void solve_distances(int unsigned n);
        t_dist       best [MAX_VERTICES];
        bit          reached [MAX_VERTICES];
        bit          done [MAX_VERTICES];
        int unsigned pick;
        int unsigned nd;
        t_vidx       hd;
        dist_word_t  r;
        for (int i = 0; i < MAX_VERTICES; i++) begin
            best[i] = '0;
            reached[i] = 1'b0;
            done[i] = 1'b0;
        end
        if (source_reg < n) begin
            reached[source_reg] = 1'b1;
            for (int rnd = 0; rnd < n; rnd++) begin
                pick = n;
                for (int i = 0; i < n; i++) begin
                    if (reached[i] && !done[i] && (pick == n || best[i] < best[pick])) begin
                        pick = i;
                    end
                end
                if (pick == n) begin
                    break;
                end
                done[pick] = 1'b1;
                for (int e = 0; e < arc_total; e++) begin
                    hd = arc_store[e].head;
                    if (arc_store[e].tail == pick && hd < n) begin
                        nd = best[pick] + arc_store[e].weight;
                        if (nd > DIST_MAX) begin
                            nd = DIST_MAX;
                        end
                        if (!reached[hd] || nd < best[hd]) begin
                            best[hd] = t_dist'(nd);
                            reached[hd] = 1'b1;
                        end
                    end
                end
            end
        end
        for (int i = 0; i < n; i++) begin
            r.vertex_index = t_vidx'(i);
            r.distance = reached[i] ? best[i] : '0;
            r.reachable = reached[i];
            r.edge_overflow = arcs_dropped;
            r.last_vertex = (i + 1 == n);
            dist_expected = {dist_expected, r};
        end
        arc_total = '0;
        arcs_dropped = 1'b0;
    endfunction

    function automatic void load_edge_word(edge_word_t w);
        int unsigned n;
        n = live_count();
        if (w.has_edge && w.from_vertex < n && w.to_vertex < n) begin
            if (arc_total < MAX_EDGES) begin
                arc_store[arc_total] = '{w.from_vertex, w.to_vertex, w.edge_weight};
                arc_total = arc_total + 1'b1;
            end else begin
                arcs_dropped = 1'b1;
            end
        end
        if (w.last_edge) begin
            solve_distances(n);
        end
    endfunction

    function automatic int unsigned pause_len();
        int unsigned r;
        r = $urandom_range(0, 99);
        if (r < 55) begin
            return 0;
        end
        if (r < 85) begin
            return $urandom_range(1, 3);
        end
        if (r < 97) begin
            return $urandom_range(4, 12);
        end
        return $urandom_range(20, 60);
    endfunction

    // edge word driver
    int unsigned edge_gap = 0;
    bit          edge_calm = 1'b0;

    always @(posedge i_clk) begin
        edge_word_t seen;
        edge_word_t w;
        if (!i_rst_n) begin
            edge_if.valid <= 1'b0;
        end else begin
            if (edge_if.valid && edge_if.ready) begin
                seen.has_edge = edge_if.has_edge;
                seen.from_vertex = edge_if.from_vertex;
                seen.to_vertex = edge_if.to_vertex;
                seen.edge_weight = edge_if.edge_weight;
                seen.last_edge = edge_if.last_edge;
                load_edge_word(seen);
            end
            if (!edge_if.valid || edge_if.ready) begin
                if (edge_gap != 0) begin
                    edge_if.valid <= 1'b0;
                    edge_gap <= edge_gap - 1;
                end else if (edges_pending.size() != 0) begin
                    w = edges_pending.pop_front();
                    edge_if.valid <= 1'b1;
                    edge_if.has_edge <= w.has_edge;
                    edge_if.from_vertex <= w.from_vertex;
                    edge_if.to_vertex <= w.to_vertex;
                    edge_if.edge_weight <= w.edge_weight;
                    edge_if.last_edge <= w.last_edge;
                    if ($urandom_range(0, 39) == 0) begin
                        edge_calm = !edge_calm;
                    end
                    edge_gap <= edge_calm ? 0 : pause_len();
                end else begin
                    edge_if.valid <= 1'b0;
                end
            end
        end
    end

    // distance word monitor
    int unsigned dist_stall = 0;
    bit          dist_calm = 1'b0;

    always @(posedge i_clk) begin
        dist_word_t want;
        if (!i_rst_n) begin
            dist_if.ready <= 1'b0;
        end else begin
            if (dist_if.valid && dist_if.ready) begin
                if (dist_expected.size() == 0) begin
                    $error("unexpected word for vertex %0d", dist_if.vertex_index);
                    mismatches++;
                end else begin
                    want = dist_expected.pop_front();
                    if (dist_if.vertex_index !== want.vertex_index) begin
                        $error("vertex_index: expected %0d, got %0d",
                               want.vertex_index, dist_if.vertex_index);
                        mismatches++;
                    end
                    if (dist_if.distance !== want.distance) begin
                        $error("distance: expected %0d, got %0d",
                               want.distance, dist_if.distance);
                        mismatches++;
                    end
                    if (dist_if.reachable !== want.reachable) begin
                        $error("reachable: expected %0d, got %0d",
                               want.reachable, dist_if.reachable);
                        mismatches++;
                    end
                    if (dist_if.edge_overflow !== want.edge_overflow) begin
                        $error("edge_overflow: expected %0d, got %0d",
                               want.edge_overflow, dist_if.edge_overflow);
                        mismatches++;
                    end
                    if (dist_if.last_vertex !== want.last_vertex) begin
                        $error("last_vertex: expected %0d, got %0d",
                               want.last_vertex, dist_if.last_vertex);
                        mismatches++;
                    end
                end
            end
            if (dist_stall != 0) begin
                dist_if.ready <= 1'b0;
                dist_stall <= dist_stall - 1;
            end else begin
                dist_if.ready <= 1'b1;
                if ($urandom_range(0, 39) == 0) begin
                    dist_calm = !dist_calm;
                end
                dist_stall <= dist_calm ? 0 : pause_len();
            end
        end
    end

    task automatic push_word(input logic has, input int unsigned from_v, input int unsigned to_v,
                             input int unsigned weight, input logic last);
        edge_word_t w;
        w.has_edge = has;
        w.from_vertex = t_vidx'(from_v);
        w.to_vertex = t_vidx'(to_v);
        w.edge_weight = t_weight'(weight);
        w.last_edge = last;
        edges_pending = {edges_pending, w};
        words_queued++;
    endtask

    // everything sent, consumed and answered
    task automatic wait_quiet();
        do begin
            @(negedge i_clk);
        end while (edges_pending.size() != 0 || edge_if.valid || dist_expected.size() != 0);
        repeat (4) @(posedge i_clk);
    endtask

    task automatic write_reg(input logic [CFG_INDEX_BITS-1:0] idx,
                             input logic [CFG_DATA_BITS-1:0] data);
        @(posedge i_clk);
        cfg_wr_en <= 1'b1;
        cfg_index <= idx;
        cfg_data <= data;
        if (idx == CFG_VERTEX_COUNT) begin
            vcount_reg = data;
        end else if (idx == CFG_SOURCE_VERTEX) begin
            source_reg = data[VERT_BITS-1:0];
        end
        @(posedge i_clk);
        cfg_wr_en <= 1'b0;
    endtask

    task automatic set_config(input int unsigned count, input int unsigned src);
        wait_quiet();
        write_reg(CFG_VERTEX_COUNT, CFG_DATA_BITS'(count));
        write_reg(CFG_SOURCE_VERTEX, CFG_DATA_BITS'(src));
    endtask

    function automatic int unsigned pick_weight();
        int unsigned r;
        r = $urandom_range(0, 9);
        if (r == 0) begin
            return 0;
        end
        if (r == 1) begin
            return 65535;
        end
        if (r < 5) begin
            return $urandom_range(0, 15);
        end
        return $urandom_range(0, 65535);
    endfunction

    initial begin
        int unsigned graph_no;
        int unsigned n;
        int unsigned m;
        int unsigned cnt;
        int unsigned fv;
        int unsigned tv;
        bit          heavy;
        edge_if.valid = 1'b0;
        edge_if.has_edge = 1'b0;
        edge_if.from_vertex = '0;
        edge_if.to_vertex = '0;
        edge_if.edge_weight = '0;
        edge_if.last_edge = 1'b0;
        dist_if.ready = 1'b0;
        repeat (10) @(posedge i_clk);
        i_rst_n <= 1'b1;

        // reset config, closing word only: only the source is reached
        push_word(0, 0, 0, 0, 1);

        // small graph: ties, zero weight, self loop, out-of-range endpoints
        set_config(5, 0);
        push_word(1, 0, 1, 65535, 0);
        push_word(1, 1, 2, 0, 0);
        push_word(1, 0, 2, 65535, 0);
        push_word(1, 2, 3, 7, 0);
        push_word(1, 3, 3, 1, 0);
        push_word(1, 0, 5, 1, 0);
        push_word(1, 63, 0, 1, 0);
        push_word(1, 0, 4, 1, 1);

        // count shrinks after edges are stored
        set_config(64, 2);
        push_word(1, 2, 40, 3, 0);
        push_word(1, 2, 1, 10, 0);
        push_word(1, 1, 0, 1, 0);
        set_config(4, 2);
        push_word(0, 63, 63, 65535, 1);

        // count zero acts as one
        set_config(0, 0);
        push_word(1, 0, 0, 5, 1);

        // count above the maximum
        set_config(127, 63);
        push_word(1, 63, 0, 65535, 1);

        // source out of range, upper data bit set
        set_config(3, 7'h43);
        push_word(1, 0, 1, 1, 0);
        push_word(1, 1, 2, 2, 1);

        graph_no = 0;
        while (words_queued < 300) begin
            if (graph_no == 4) begin
                // store overflow
                set_config($urandom_range(2, 64), 0);
                n = live_count();
                m = MAX_EDGES + $urandom_range(1, 8);
                for (int i = 0; i < m; i++) begin
                    push_word(1, $urandom_range(0, n - 1), $urandom_range(0, n - 1),
                              $urandom_range(0, 1000), i + 1 == m);
                end
            end
            if (graph_no == 0 || $urandom_range(0, 2) == 0) begin
                case ($urandom_range(0, 19))
                    0: cnt = 0;
                    1: cnt = $urandom_range(65, 127);
                    2, 3, 4: cnt = 64;
                    5: cnt = 1;
                    default: cnt = $urandom_range(2, 16);
                endcase
                n = (cnt == 0) ? 1 : ((cnt > 64) ? 64 : cnt);
                if ($urandom_range(0, 9) == 0) begin
                    set_config(cnt, $urandom_range(0, 127));
                end else begin
                    set_config(cnt, $urandom_range(0, n - 1) + 64 * $urandom_range(0, 1));
                end
            end
            n = live_count();
            if ($urandom_range(0, 7) == 0) begin
                // chain through every vertex
                heavy = $urandom_range(0, 1);
                for (int v = 0; v + 1 < n; v++) begin
                    push_word(1, v, v + 1, heavy ? 65535 : pick_weight(), 0);
                end
            end else begin
                m = $urandom_range(0, (n < 8) ? 3 * n : 40);
                for (int i = 0; i < m; i++) begin
                    if ($urandom_range(0, 19) == 0) begin
                        push_word(0, $urandom_range(0, 63), $urandom_range(0, 63),
                                  $urandom_range(0, 65535), 0);
                    end else begin
                        if ($urandom_range(0, 9) == 0) begin
                            fv = $urandom_range(0, 63);
                            tv = $urandom_range(0, 63);
                        end else begin
                            fv = $urandom_range(0, n - 1);
                            tv = $urandom_range(0, n - 1);
                        end
                        push_word(1, fv, tv, pick_weight(), 0);
                    end
                end
            end
            if ($urandom_range(0, 1) == 0) begin
                push_word(1, $urandom_range(0, n - 1), $urandom_range(0, n - 1),
                          pick_weight(), 1);
            end else begin
                push_word(0, $urandom_range(0, 63), $urandom_range(0, 63),
                          $urandom_range(0, 65535), 1);
            end
            graph_no++;
        end

        wait_quiet();
        repeat (100) @(posedge i_clk);
        if (mismatches == 0) begin
            $display("testbench OK");
        end else begin
            $display("testbench NOT OK");
        end
        $finish;
    end

    initial begin
        #10_000_000;
        $display("testbench NOT OK");
        $finish;
    end

endmodule
